// ----- sv/rsq_pkg.sv -----
`default_nettype none
package rsq_pkg;
    localparam int SUM_W = 32;
    localparam int VALUE_W = 32;
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REBUILD,
        ST_LOOKUP,
        ST_RESULT
    } state_t;
endpackage
`default_nettype wire

// ----- sv/rsq_req_if.sv -----
`default_nettype none
interface rsq_req_if #(parameter int INDEX_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [INDEX_BITS-1:0] index;
    logic [31:0]           value;
    logic [INDEX_BITS-1:0] left;
    logic [INDEX_BITS:0]   right;
    modport source (output valid, mode, index, value, left, right, input ready);
    modport sink   (input valid, mode, index, value, left, right, output ready);
endinterface
`default_nettype wire

// ----- sv/rsq_rsp_if.sv -----
`default_nettype none
interface rsq_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] sum;
    logic        error;
    modport source (output valid, sum, error, input ready);
    modport sink   (input valid, sum, error, output ready);
endinterface
`default_nettype wire

// ----- sv/rsq_cfg_if.sv -----
`default_nettype none
interface rsq_cfg_if #(parameter int INDEX_BITS = 10);
    logic                valid;
    logic                ready;
    logic [INDEX_BITS:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- sv/rsq_ram.sv -----
`default_nettype none
module rsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- sv/range_sum_query_engine_unit.sv -----
// lookup: a query on fresh tables reads prefix[right], then prefix[left], and registers
//   their difference as the result; an in-range query after a load or length write first
//   rebuilds the prefix table, one element read and one write per cycle
// throughput: loads one per cycle while idle; a query holds the input until its result
//   is taken, so the next request is taken only after the block returns to idle
// reset: after rst_n the element store is swept to zero while no request is taken;
//   length resets to zero
`default_nettype none
module range_sum_query_engine_unit #(
    parameter int INDEX_BITS = 10,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rsq_req_if.sink   req,
    rsq_cfg_if.sink   cfg,
    rsq_rsp_if.source rsp
);
    import rsq_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;
    localparam int PW = INDEX_BITS + 1;

    state_t state_reg, state_next;
    logic [INDEX_BITS:0]   len_reg;
    logic                  stale_reg;
    logic [INDEX_BITS:0]   cnt_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [INDEX_BITS-1:0] left_reg;
    logic [INDEX_BITS:0]   right_reg;
    logic                  err_reg;
    logic [SUM_W-1:0]      sum_reg;

    // element store and prefix table, prefix[k] = sum of elements below k
    logic                  e_we;
    logic [INDEX_BITS-1:0] e_waddr, e_raddr;
    logic [DATA_WIDTH-1:0] e_wdata, e_rdata;
    logic                  p_we;
    logic [PW-1:0]         p_waddr, p_raddr;
    logic [DATA_WIDTH-1:0] p_wdata, p_rdata;
    logic [DATA_WIDTH-1:0] p_hi_reg;

    rsq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_elem (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );
    rsq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(2 * DEPTH)) u_pref (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    logic req_fire, cfg_fire, bad;
    assign req_fire = req.valid && req.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign bad = (req.left > req.right) || (req.right > len_reg);
    assign req.ready = (state_reg == ST_IDLE);
    // length only changes between requests
    assign cfg.ready = (state_reg == ST_IDLE);
    assign rsp.valid = (state_reg == ST_RESULT);
    assign rsp.sum = sum_reg;
    assign rsp.error = err_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (cnt_reg == (INDEX_BITS+1)'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            ST_IDLE:
                if (req_fire && req.mode == MODE_QUERY)
                begin
                    if (bad)
                    begin
                        state_next = ST_RESULT;
                    end
                    else if (stale_reg)
                    begin
                        state_next = ST_REBUILD;
                    end
                    else
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            ST_REBUILD:
                if (cnt_reg == (INDEX_BITS+1)'(DEPTH))
                begin
                    state_next = ST_LOOKUP;
                end
            ST_LOOKUP:
                if (cnt_reg == (INDEX_BITS+1)'(2))
                begin
                    state_next = ST_RESULT;
                end
            ST_RESULT:
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory port steering
    always_comb
    begin
        e_we = 1'b0;
        e_waddr = cnt_reg[INDEX_BITS-1:0];
        e_wdata = '0;
        e_raddr = cnt_reg[INDEX_BITS-1:0];
        p_we = 1'b0;
        p_waddr = cnt_reg;
        p_wdata = acc_reg;
        p_raddr = right_reg;
        unique case (state_reg)
            ST_CLEAR:
                e_we = 1'b1;
            ST_IDLE:
            begin
                e_we = req_fire && req.mode == MODE_LOAD;
                e_waddr = req.index;
                e_wdata = DATA_WIDTH'(req.value);
                e_raddr = '0;
            end
            ST_REBUILD:
            begin
                // cnt walks 0..DEPTH; element cnt is read ahead of its use
                p_we = 1'b1;
                e_raddr = cnt_reg[INDEX_BITS-1:0] + 1'b1;
            end
            ST_LOOKUP:
                p_raddr = (cnt_reg == '0) ? right_reg : PW'(left_reg);
            default: ;
        endcase
    end

    logic [DATA_WIDTH-1:0] elem_in;
    assign elem_in = (cnt_reg < len_reg) ? e_rdata : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            len_reg <= '0;
            stale_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
            begin
                len_reg <= (cfg.data > PW'(DEPTH)) ? PW'(DEPTH) : cfg.data;
            end
            if (cfg_fire || (req_fire && req.mode == MODE_LOAD))
            begin
                stale_reg <= 1'b1;
            end
            else if (state_reg == ST_REBUILD && state_next == ST_LOOKUP)
            begin
                stale_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                    cnt_reg <= (state_next == ST_IDLE) ? '0 : cnt_reg + 1'b1;
                ST_IDLE:
                    cnt_reg <= '0;
                ST_REBUILD:
                    cnt_reg <= (state_next == ST_LOOKUP) ? '0 : cnt_reg + 1'b1;
                ST_LOOKUP:
                    cnt_reg <= cnt_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // payload; element 0 is read in idle so the rebuild starts primed
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_fire)
        begin
            left_reg <= req.left;
            right_reg <= req.right;
            err_reg <= bad;
            sum_reg <= '0;
            acc_reg <= '0;
        end
        if (state_reg == ST_REBUILD)
        begin
            acc_reg <= acc_reg + elem_in;
        end
        if (state_reg == ST_LOOKUP && cnt_reg == PW'(1))
        begin
            p_hi_reg <= p_rdata;
        end
        if (state_reg == ST_LOOKUP && cnt_reg == PW'(2))
        begin
            sum_reg <= SUM_W'(p_hi_reg - p_rdata);
        end
    end

    property p_no_take_busy;
        @(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready;
    endproperty
    a_no_take_busy: assert property (p_no_take_busy) else $error("request taken while busy");

    property p_err_zero;
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.error) |-> (rsp.sum == '0);
    endproperty
    a_err_zero: assert property (p_err_zero) else $error("error result with nonzero sum");

    property p_lookup_fresh;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |-> !stale_reg;
    endproperty
    a_lookup_fresh: assert property (p_lookup_fresh) else $error("lookup on stale tables");
endmodule
`default_nettype wire

// ----- tb/tb_range_sum_query_engine_unit.sv -----
`default_nettype none
module tb_range_sum_query_engine_unit;
    import rsq_pkg::*;

    localparam int INDEX_BITS = 10;
    localparam int DEPTH = 1 << INDEX_BITS;
    // a rebuild or the reset sweep, with margin
    localparam int SETTLE_CYCLES = DEPTH + 100;
    localparam int CYCLE_LIMIT = 3000000;

    typedef enum logic [1:0] {K_LOAD, K_QUERY, K_LENGTH, K_DRAIN} kind_t;

    typedef struct {
        kind_t                 kind;
        logic [INDEX_BITS-1:0] index;
        logic [VALUE_W-1:0]    value;
        logic [INDEX_BITS-1:0] left;
        logic [INDEX_BITS:0]   right;
    } request_t;

    typedef struct {
        logic [SUM_W-1:0] sum;
        logic             error;
    } range_result_t;

    logic clk;
    logic rst_n;

    rsq_req_if #(.INDEX_BITS(INDEX_BITS)) req_ch ();
    rsq_cfg_if #(.INDEX_BITS(INDEX_BITS)) cfg_ch ();
    rsq_rsp_if                            rsp_ch ();

    range_sum_query_engine_unit #(.INDEX_BITS(INDEX_BITS), .DATA_WIDTH(32)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .cfg   (cfg_ch),
        .rsp   (rsp_ch)
    );

    request_t      pending_requests[$];
    range_result_t expected_sums[$];

    logic [VALUE_W-1:0]  element_copy [DEPTH];
    logic [INDEX_BITS:0] length_copy;

    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned load_count;
    int unsigned query_count;
    int unsigned error_count;
    int unsigned length_writes;
    int unsigned send_gap;
    int unsigned quiet_cycles;
    int unsigned stall_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void predict_range_sum(request_t r);
        range_result_t res;
        res.sum = '0;
        res.error = 1'b0;
        if (r.left > r.right || r.right > length_copy)
        begin
            res.error = 1'b1;
            error_count++;
        end
        else
        begin
            for (int k = r.left; k < r.right; k++)
                res.sum = res.sum + element_copy[k];
        end
        expected_sums = {expected_sums, res};
        query_count++;
    endfunction

    function automatic void push_load(int unsigned idx, logic [31:0] val);
        request_t r;
        r.kind = K_LOAD;
        r.index = idx[INDEX_BITS-1:0];
        r.value = val;
        r.left = INDEX_BITS'($urandom());
        r.right = (INDEX_BITS+1)'($urandom());
        pending_requests = {pending_requests, r};
    endfunction

    function automatic void push_query(int unsigned lo, int unsigned hi);
        request_t r;
        r.kind = K_QUERY;
        r.index = INDEX_BITS'($urandom());
        r.value = $urandom();
        r.left = lo[INDEX_BITS-1:0];
        r.right = hi[INDEX_BITS:0];
        pending_requests = {pending_requests, r};
    endfunction

    function automatic void push_marker(kind_t k, int unsigned len);
        request_t r;
        r.kind = k;
        r.index = '0;
        r.value = '0;
        r.left = '0;
        r.right = len[INDEX_BITS:0];
        pending_requests = {pending_requests, r};
    endfunction

    // sender: loads and queries go as soon as the gap allows, length writes and
    // drains wait until the block has gone quiet
    always @(posedge clk or negedge rst_n)
    begin
        logic     next_req_valid;
        logic     next_cfg_valid;
        request_t r;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.mode  <= MODE_LOAD;
            req_ch.index <= '0;
            req_ch.value <= '0;
            req_ch.left  <= '0;
            req_ch.right <= '0;
            cfg_ch.valid <= 1'b0;
            cfg_ch.data  <= '0;
            send_gap     = 0;
            quiet_cycles = 0;
        end
        else
        begin
            next_req_valid = req_ch.valid;
            next_cfg_valid = cfg_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                if (req_ch.mode == MODE_QUERY)
                begin
                    r.left = req_ch.left;
                    r.right = req_ch.right;
                    predict_range_sum(r);
                end
                else
                begin
                    element_copy[req_ch.index] = req_ch.value;
                    load_count++;
                end
                next_req_valid = 1'b0;
                send_gap = $urandom_range(0, 11);
                quiet_cycles = 0;
            end
            else if (cfg_ch.valid && cfg_ch.ready)
            begin
                length_copy = (cfg_ch.data > DEPTH) ? DEPTH[INDEX_BITS:0] : cfg_ch.data;
                length_writes++;
                next_cfg_valid = 1'b0;
                send_gap = $urandom_range(0, 11);
                quiet_cycles = 0;
            end
            else if (rsp_ch.valid && rsp_ch.ready)
                quiet_cycles = 0;
            else if (quiet_cycles < SETTLE_CYCLES)
                quiet_cycles++;

            if (!next_req_valid && !next_cfg_valid)
            begin
                if (send_gap != 0)
                    send_gap--;
                else if (pending_requests.size() != 0)
                begin
                    r = pending_requests[0];
                    if (r.kind == K_LOAD || r.kind == K_QUERY)
                    begin
                        void'(pending_requests.pop_front());
                        req_ch.mode  <= (r.kind == K_QUERY) ? MODE_QUERY : MODE_LOAD;
                        req_ch.index <= r.index;
                        req_ch.value <= r.value;
                        req_ch.left  <= r.left;
                        req_ch.right <= r.right;
                        next_req_valid = 1'b1;
                    end
                    else if (expected_sums.size() == 0 && quiet_cycles >= SETTLE_CYCLES)
                    begin
                        void'(pending_requests.pop_front());
                        if (r.kind == K_LENGTH)
                        begin
                            cfg_ch.data <= r.right;
                            next_cfg_valid = 1'b1;
                        end
                    end
                end
            end
            req_ch.valid <= next_req_valid;
            cfg_ch.valid <= next_cfg_valid;
        end
    end

    // receiver with random stalls, checks each result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        range_result_t exp_res;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: sum=%h error=%b", rsp_ch.sum, rsp_ch.error);
                end
                else
                begin
                    exp_res = expected_sums.pop_front();
                    if (rsp_ch.sum !== exp_res.sum || rsp_ch.error !== exp_res.error)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected sum=%h error=%b, got sum=%h error=%b",
                                     exp_res.sum, exp_res.error, rsp_ch.sum, rsp_ch.error);
                    end
                end
                stall_left = $urandom_range(0, 11);
            end
            else if (stall_left != 0)
                stall_left--;
            rsp_ch.ready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_sums.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned len;
        int unsigned lo;
        int unsigned hi;
        int unsigned pick;
        cycle_count = 0;
        mismatch_count = 0;
        load_count = 0;
        query_count = 0;
        error_count = 0;
        length_writes = 0;
        length_copy = '0;
        for (int k = 0; k < DEPTH; k++)
            element_copy[k] = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        push_marker(K_LENGTH, 0);
        push_query(0, 0);
        push_query(0, 1);
        push_marker(K_LENGTH, DEPTH);
        push_load(0, 32'hffff_ffff);
        push_load(DEPTH - 1, 32'hffff_ffff);
        push_load(1, 32'h0000_0001);
        push_load(682, 32'haaaa_aaaa);
        push_load(341, 32'h5555_5555);
        push_query(0, DEPTH);
        push_query(DEPTH - 1, DEPTH);
        push_query(0, 2);
        push_query(0, 1);
        push_query(5, 3);
        push_query(DEPTH - 1, DEPTH - 1);
        push_query(DEPTH - 1, 2047);
        push_query(341, 683);
        push_marker(K_DRAIN, 0);
        push_marker(K_LENGTH, 2047);
        push_query(0, DEPTH);
        push_marker(K_LENGTH, 10);
        push_load(20, 32'h1234_5678);
        push_query(0, 10);
        push_query(3, 11);

        // random phases, each under its own length
        for (int ph = 0; ph < 8; ph++)
        begin
            pick = $urandom_range(0, 5);
            case (pick)
                0: len = 0;
                1: len = DEPTH;
                2: len = $urandom_range(DEPTH + 1, 2047);
                3: len = $urandom_range(1, 4);
                default: len = $urandom_range(1, DEPTH);
            endcase
            push_marker(K_LENGTH, len);
            if (len > DEPTH)
                len = DEPTH;
            for (int n = 0; n < 50; n++)
            begin
                pick = $urandom_range(0, 99);
                if (n == 25)
                    push_marker(K_DRAIN, 0);
                if (pick < 30)
                begin
                    // mostly inside the valid range, some anywhere
                    if (len != 0 && pick < 25)
                        push_load($urandom_range(0, len - 1), $urandom());
                    else
                        push_load($urandom_range(0, DEPTH - 1), $urandom());
                end
                else if (pick < 85 && len != 0)
                begin
                    lo = $urandom_range(0, len - 1);
                    if (pick < 45)
                        hi = lo + $urandom_range(0, 2);
                    else
                        hi = $urandom_range(lo, len);
                    if (hi > len)
                        hi = len;
                    push_query(lo, hi);
                end
                else
                    push_query($urandom_range(0, DEPTH - 1), $urandom_range(0, 2047));
            end
        end

        wait (pending_requests.size() == 0 && !req_ch.valid && !cfg_ch.valid
              && expected_sums.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d loads, %0d queries (%0d invalid ranges), %0d length writes",
                 load_count, query_count, error_count, length_writes);
        $display("%0d cycles, %0d mismatches", cycle_count, mismatch_count);
        if (mismatch_count == 0 && expected_sums.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
